/* sv/ipv4fw_pkg.sv */
// ---------------------------------------------------------------------------
// ipv4fw_pkg
// Shared types, constants and codes of the IPv4 forwarding header rewrite.
// ---------------------------------------------------------------------------
package ipv4fw_pkg;

    // route table size and index width
    localparam int ROUTE_ENTRIES = 8;
    localparam int RT_IDX_W      = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    // header store geometry
    localparam int HDR_MAX  = 30;
    localparam int HDR_AW   = $clog2(HDR_MAX);
    localparam int WORD_W   = 16;
    localparam int SUM_W    = 21;
    localparam int CNT_W    = 5;

    // configuration register indexes
    localparam logic CFG_ACCEPTED_SOURCE = 1'b0;
    localparam logic CFG_OWN_MAC         = 1'b1;

    // input opcodes
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // verdict codes
    localparam logic [2:0] V_FORWARD   = 3'd0;
    localparam logic [2:0] V_WRONG_SRC = 3'd1;
    localparam logic [2:0] V_TTL       = 3'd2;
    localparam logic [2:0] V_NO_ROUTE  = 3'd3;
    localparam logic [2:0] V_MALFORMED = 3'd4;

    // smallest legal header length field
    localparam logic [3:0] IHL_MIN = 4'd5;

    // fixed header word positions
    localparam logic [HDR_AW-1:0] W_TTL    = HDR_AW'(4);
    localparam logic [HDR_AW-1:0] W_CSUM   = HDR_AW'(5);
    localparam logic [HDR_AW-1:0] W_SRC_HI = HDR_AW'(6);
    localparam logic [HDR_AW-1:0] W_SRC_LO = HDR_AW'(7);
    localparam logic [HDR_AW-1:0] W_DST_HI = HDR_AW'(8);
    localparam logic [HDR_AW-1:0] W_DST_LO = HDR_AW'(9);

    // sequencer states
    typedef enum logic [3:0] {
        S_COLLECT,
        S_CHECK,
        S_SCAN,
        S_SUM,
        S_FOLD,
        S_FIX,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    // route table write request
    typedef struct packed {
        logic                en;
        logic [RT_IDX_W-1:0] idx;
        logic [31:0]         addr;
        logic [47:0]         mac;
        logic                enable;
    } t_route_wr;

endpackage

/* sv/ipv4fw_ram.sv */
// ---------------------------------------------------------------------------
// ipv4fw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module ipv4fw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ipv4fw_route.sv */
// ---------------------------------------------------------------------------
// ipv4fw_route
// Route table: destination address, next-hop mac and enable per slot, with
// one compare port driven by the lookup scan index.
// ---------------------------------------------------------------------------
module ipv4fw_route (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ipv4fw_pkg::t_route_wr         i_wr,
    input  logic [ipv4fw_pkg::RT_IDX_W-1:0] i_scan_idx,
    input  logic [31:0]                   i_dst,
    output logic                          o_hit,
    output logic [47:0]                   o_mac
);

    logic [31:0] r_addr  [ipv4fw_pkg::ROUTE_ENTRIES];
    logic [47:0] r_mac   [ipv4fw_pkg::ROUTE_ENTRIES];
    logic [ipv4fw_pkg::ROUTE_ENTRIES-1:0] r_valid;

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_addr[i_wr.idx] <= i_wr.addr;
            r_mac[i_wr.idx]  <= i_wr.mac;
        end
    end

    // enable bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= i_wr.enable;
        end
    end

    // single shared compare on the scanned slot
    assign o_hit = r_valid[i_scan_idx] && (r_addr[i_scan_idx] == i_dst);
    assign o_mac = r_mac[i_scan_idx];

endmodule

/* sv/ipv4_forward_header_rewrite_top.sv */
// ---------------------------------------------------------------------------
// ipv4_forward_header_rewrite_top
// Collects IPv4 header words, checks source and ttl, scans the route table,
// recomputes the checksum and sends the rewritten header with mac addresses.
// ---------------------------------------------------------------------------
// Header words and route writes are taken one per cycle while a header is collected.
// After the last word it checks source and ttl, scans the route table, sums the
// header ram words and folds the sum, then emits each word in read, load and present
// states, subject to output stall; a drop verdict is presented in the cycle after the
// check or last lookup. Input is not ready until the last result is taken.
// Synchronous active-low reset clears sequencer, counters, route enables and config.
module ipv4_forward_header_rewrite_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [2:0]  i_route_slot,
    input  logic [31:0] i_route_address,
    input  logic [47:0] i_route_next_hop,
    input  logic        i_route_enable,
    input  logic [15:0] i_header_word,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_out_word,
    output logic        o_out_last,
    output logic [47:0] o_dst_mac_out,
    output logic [47:0] o_src_mac_out
);

    localparam int AW = ipv4fw_pkg::HDR_AW;
    localparam int SW = ipv4fw_pkg::SUM_W;
    localparam int CW = ipv4fw_pkg::CNT_W;
    localparam int RW = ipv4fw_pkg::RT_IDX_W;

    // configuration registers
    logic [31:0] r_acc_src;
    logic [47:0] r_own_mac;

    // sequencer and counters
    ipv4fw_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_seen, n_seen;
    logic [CW-1:0] r_expected, n_expected;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_pend, n_pend;
    logic [RW-1:0] r_scan, n_scan;

    // captured header fields and working values
    logic [15:0] r_w4, n_w4;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [47:0] r_hop, n_hop;
    logic [SW-1:0] r_sum, n_sum;
    logic [15:0] r_csum, n_csum;

    // output word register
    logic [2:0]  r_verdict, n_verdict;
    logic [15:0] r_word, n_word;
    logic        r_last, n_last;
    logic [47:0] r_dmac, n_dmac;
    logic [47:0] r_smac, n_smac;

    // helpers
    logic              in_acc;
    logic              out_acc;
    logic [3:0]        ihl;
    logic [CW-1:0]     cur_expected;
    logic [CW-1:0]     seen_inc;
    logic [15:0]       w4_mod;
    logic [15:0]       sum_word;
    logic              ram_we;
    logic [15:0]       ram_rdata;
    logic              rt_hit;
    logic [47:0]       rt_mac;
    ipv4fw_pkg::t_route_wr rt_wr;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign ihl     = i_header_word[11:8];
    assign w4_mod  = {r_w4[15:8] - 8'd1, r_w4[7:0]};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_src <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ipv4fw_pkg::CFG_ACCEPTED_SOURCE: r_acc_src <= i_cfg_data[31:0];
                ipv4fw_pkg::CFG_OWN_MAC:         r_own_mac <= i_cfg_data;
            endcase
        end
    end

    // route table write from the input channel
    always_comb begin
        rt_wr.en     = in_acc && (i_opcode == ipv4fw_pkg::OP_ROUTE)
                       && (32'(i_route_slot) < 32'(ipv4fw_pkg::ROUTE_ENTRIES));
        rt_wr.idx    = RW'(i_route_slot);
        rt_wr.addr   = i_route_address;
        rt_wr.mac    = i_route_next_hop;
        rt_wr.enable = i_route_enable;
    end

    ipv4fw_route u_route (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (rt_wr),
        .i_scan_idx (r_scan),
        .i_dst      (r_dst),
        .o_hit      (rt_hit),
        .o_mac      (rt_mac)
    );

    // header word store
    assign ram_we = in_acc && (i_opcode == ipv4fw_pkg::OP_WORD)
                    && (r_state == ipv4fw_pkg::S_COLLECT)
                    && !((r_seen == '0) && (ihl < ipv4fw_pkg::IHL_MIN));

    ipv4fw_ram #(
        .WIDTH (ipv4fw_pkg::WORD_W),
        .DEPTH (ipv4fw_pkg::HDR_MAX)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_seen)),
        .i_wdata (i_header_word),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ipv4fw_pkg::S_COLLECT;
            r_seen     <= '0;
            r_expected <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seen     <= n_seen;
            r_expected <= n_expected;
            r_pend     <= n_pend;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_pidx    <= n_pidx;
        r_scan    <= n_scan;
        r_w4      <= n_w4;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_hop     <= n_hop;
        r_sum     <= n_sum;
        r_csum    <= n_csum;
        r_verdict <= n_verdict;
        r_word    <= n_word;
        r_last    <= n_last;
        r_dmac    <= n_dmac;
        r_smac    <= n_smac;
    end

    // word fed to the checksum adder, ttl and checksum words substituted
    always_comb begin
        if (r_pidx == ipv4fw_pkg::W_TTL) begin
            sum_word = w4_mod;
        end else if (r_pidx == ipv4fw_pkg::W_CSUM) begin
            sum_word = '0;
        end else begin
            sum_word = ram_rdata;
        end
    end

    assign cur_expected = (r_seen == '0) ? CW'({ihl, 1'b0}) : r_expected;
    assign seen_inc     = r_seen + CW'(1);

    // next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_seen     = r_seen;
        n_expected = r_expected;
        n_addr     = r_addr;
        n_pidx     = r_pidx;
        n_pend     = 1'b0;
        n_scan     = r_scan;
        n_w4       = r_w4;
        n_src      = r_src;
        n_dst      = r_dst;
        n_hop      = r_hop;
        n_sum      = r_sum;
        n_csum     = r_csum;
        n_verdict  = r_verdict;
        n_word     = r_word;
        n_last     = r_last;
        n_dmac     = r_dmac;
        n_smac     = r_smac;

        unique case (r_state)
            ipv4fw_pkg::S_COLLECT: begin
                if (in_acc && (i_opcode == ipv4fw_pkg::OP_WORD)) begin
                    if ((r_seen == '0) && (ihl < ipv4fw_pkg::IHL_MIN)) begin
                        // malformed first word gives a single verdict
                        n_verdict = ipv4fw_pkg::V_MALFORMED;
                        n_word    = '0;
                        n_last    = 1'b1;
                        n_dmac    = '0;
                        n_smac    = '0;
                        n_state   = ipv4fw_pkg::S_OUT;
                    end else begin
                        // capture fields needed by the decision
                        if (AW'(r_seen) == ipv4fw_pkg::W_TTL)    n_w4 = i_header_word;
                        if (AW'(r_seen) == ipv4fw_pkg::W_SRC_HI) n_src[31:16] = i_header_word;
                        if (AW'(r_seen) == ipv4fw_pkg::W_SRC_LO) n_src[15:0]  = i_header_word;
                        if (AW'(r_seen) == ipv4fw_pkg::W_DST_HI) n_dst[31:16] = i_header_word;
                        if (AW'(r_seen) == ipv4fw_pkg::W_DST_LO) n_dst[15:0]  = i_header_word;
                        if (seen_inc >= cur_expected) begin
                            n_seen     = '0;
                            n_expected = cur_expected;
                            n_state    = ipv4fw_pkg::S_CHECK;
                        end else begin
                            n_seen     = seen_inc;
                            n_expected = cur_expected;
                        end
                    end
                end
            end

            ipv4fw_pkg::S_CHECK: begin
                n_word = '0;
                n_last = 1'b1;
                n_dmac = '0;
                n_smac = '0;
                if (r_src != r_acc_src) begin
                    n_verdict = ipv4fw_pkg::V_WRONG_SRC;
                    n_state   = ipv4fw_pkg::S_OUT;
                end else if (r_w4[15:9] == '0) begin
                    n_verdict = ipv4fw_pkg::V_TTL;
                    n_state   = ipv4fw_pkg::S_OUT;
                end else begin
                    n_scan  = '0;
                    n_state = ipv4fw_pkg::S_SCAN;
                end
            end

            ipv4fw_pkg::S_SCAN: begin
                // one slot per cycle, lowest matching slot wins
                if (rt_hit) begin
                    n_hop   = rt_mac;
                    n_addr  = '0;
                    n_sum   = '0;
                    n_state = ipv4fw_pkg::S_SUM;
                end else if (r_scan == RW'(ipv4fw_pkg::ROUTE_ENTRIES - 1)) begin
                    n_verdict = ipv4fw_pkg::V_NO_ROUTE;
                    n_word    = '0;
                    n_last    = 1'b1;
                    n_dmac    = '0;
                    n_smac    = '0;
                    n_state   = ipv4fw_pkg::S_OUT;
                end else begin
                    n_scan = r_scan + RW'(1);
                end
            end

            ipv4fw_pkg::S_SUM: begin
                // issue reads in order, accumulate the word read last cycle
                if (CW'(r_addr) != r_expected) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    n_addr = r_addr + AW'(1);
                end
                if (r_pend) begin
                    n_sum = r_sum + SW'(sum_word);
                    if (CW'(r_pidx) == r_expected - CW'(1)) begin
                        n_state = ipv4fw_pkg::S_FOLD;
                    end
                end
            end

            ipv4fw_pkg::S_FOLD: begin
                // first end-around carry fold
                n_sum   = SW'(r_sum[15:0]) + SW'(r_sum[SW-1:16]);
                n_state = ipv4fw_pkg::S_FIX;
            end

            ipv4fw_pkg::S_FIX: begin
                // second fold and inversion
                n_csum  = ~(r_sum[15:0] + 16'(r_sum[16]));
                n_addr  = '0;
                n_state = ipv4fw_pkg::S_RD;
            end

            ipv4fw_pkg::S_RD: begin
                // read address settles, data arrives next cycle
                n_state = ipv4fw_pkg::S_LOAD;
            end

            ipv4fw_pkg::S_LOAD: begin
                if (r_addr == ipv4fw_pkg::W_TTL) begin
                    n_word = w4_mod;
                end else if (r_addr == ipv4fw_pkg::W_CSUM) begin
                    n_word = r_csum;
                end else begin
                    n_word = ram_rdata;
                end
                n_verdict = ipv4fw_pkg::V_FORWARD;
                n_last    = (CW'(r_addr) == r_expected - CW'(1));
                n_dmac    = r_hop;
                n_smac    = r_own_mac;
                n_state   = ipv4fw_pkg::S_OUT;
            end

            ipv4fw_pkg::S_OUT: begin
                if (out_acc) begin
                    if (r_last) begin
                        n_state = ipv4fw_pkg::S_COLLECT;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_state = ipv4fw_pkg::S_RD;
                    end
                end
            end

            default: begin
                n_state = ipv4fw_pkg::S_COLLECT;
            end
        endcase
    end

    // ports
    assign o_in_ready     = (r_state == ipv4fw_pkg::S_COLLECT);
    assign o_out_valid    = (r_state == ipv4fw_pkg::S_OUT);
    assign o_verdict      = r_verdict;
    assign o_out_word     = r_word;
    assign o_out_last     = r_last;
    assign o_dst_mac_out  = r_dmac;
    assign o_src_mac_out  = r_smac;

endmodule

/* dv/tb_ipv4_forward_header_rewrite_top.sv */
// ---------------------------------------------------------------------------
// tb_ipv4_forward_header_rewrite_top
// Self-checking bench for the IPv4 forwarding header rewrite. Route writes
// and header words go in over a valid/ready channel. A behavioural copy of
// the route table and header store works out every egress word: the verdict
// on a drop, or the rewritten header with ttl and checksum fixed and both mac
// addresses on a forward. Each word the block hands out is compared, field by
// field, in order. Directed cases cover the corners, then random traffic with
// bursty idling on both sides, a long receiver hold-off and a flat-out finish.
// ---------------------------------------------------------------------------
module tb_ipv4_forward_header_rewrite_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4fw_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 120;
    localparam int FLAT_ITEMS    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PACKETS  = 3;
    localparam int PRINT_CAP     = 50;

    typedef logic [HDR_MAX-1:0][WORD_W-1:0] hdr_words_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] word;
        logic        last;
        logic [47:0] dmac;
        logic [47:0] smac;
    } egress_word_t;

    typedef enum int {
        PK_FORWARD,
        PK_WRONG_SRC,
        PK_TTL_LOW,
        PK_NO_ROUTE,
        PK_MALFORMED,
        PK_ROUTE,
        PK_NOISE
    } pkt_kind_e;

    // block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    logic [2:0]  i_route_slot;
    logic [31:0] i_route_address;
    logic [47:0] i_route_next_hop;
    logic        i_route_enable;
    logic [15:0] i_header_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_verdict;
    logic [15:0] o_out_word;
    logic        o_out_last;
    logic [47:0] o_dst_mac_out;
    logic [47:0] o_src_mac_out;

    // forwarding state mirrored from the block
    logic [31:0] fw_accept_src;
    logic [47:0] fw_own_mac;
    logic [15:0] fw_hdr [HDR_MAX];
    int          fw_seen;
    int          fw_need;
    logic [31:0] fw_rt_addr  [ROUTE_ENTRIES];
    logic [47:0] fw_rt_mac   [ROUTE_ENTRIES];
    logic        fw_rt_valid [ROUTE_ENTRIES];

    egress_word_t egress_q [$];

    // bench controls and tallies
    bit          tx_gaps   = 1'b1;
    bit          rx_stalls = 1'b1;
    int          hold_req  = 0;
    int          err_count = 0;
    int          items_sent = 0;
    int          route_writes = 0;
    int          words_checked = 0;
    int          cycle_count;
    int          verdict_tally [8];
    logic [31:0] dst_pool [ROUTE_ENTRIES];

    ipv4_forward_header_rewrite_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_route_slot     (i_route_slot),
        .i_route_address  (i_route_address),
        .i_route_next_hop (i_route_next_hop),
        .i_route_enable   (i_route_enable),
        .i_header_word    (i_header_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_verdict        (o_verdict),
        .o_out_word       (o_out_word),
        .o_out_last       (o_out_last),
        .o_dst_mac_out    (o_dst_mac_out),
        .o_src_mac_out    (o_src_mac_out)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic flag_mismatch(string msg);
        if (err_count < PRINT_CAP) begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // forwarding predictor
    // ------------------------------------------------------------------
    task automatic push_egress(logic [2:0] v, logic [15:0] w, logic l,
                               logic [47:0] d, logic [47:0] s);
        egress_word_t e;
        e.verdict = v;
        e.word    = w;
        e.last    = l;
        e.dmac    = d;
        e.smac    = s;
        egress_q.push_back(e);
        if (l) verdict_tally[v]++;
    endtask

    // checks in order: source, ttl, route; forwards with ttl and checksum fixed
    task automatic decide_and_rewrite();
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] sum;
        logic [7:0]  ttl;
        logic [47:0] hop;
        bit          found;
        src   = {fw_hdr[W_SRC_HI], fw_hdr[W_SRC_LO]};
        dst   = {fw_hdr[W_DST_HI], fw_hdr[W_DST_LO]};
        ttl   = fw_hdr[W_TTL][15:8];
        hop   = '0;
        found = 1'b0;
        if (src != fw_accept_src) begin
            push_egress(V_WRONG_SRC, '0, 1'b1, '0, '0);
        end else if (ttl <= 8'd1) begin
            push_egress(V_TTL, '0, 1'b1, '0, '0);
        end else begin
            // lowest enabled matching slot wins
            for (int i = 0; i < ROUTE_ENTRIES; i++) begin
                if (!found && fw_rt_valid[i] && fw_rt_addr[i] == dst) begin
                    hop   = fw_rt_mac[i];
                    found = 1'b1;
                end
            end
            if (!found) begin
                push_egress(V_NO_ROUTE, '0, 1'b1, '0, '0);
            end else begin
                fw_hdr[W_TTL]  = {ttl - 8'd1, fw_hdr[W_TTL][7:0]};
                fw_hdr[W_CSUM] = '0;
                sum = '0;
                for (int i = 0; i < fw_need && i < HDR_MAX; i++) sum += fw_hdr[i];
                // fold carries back twice, then invert
                sum = (sum >> 16) + {16'd0, sum[15:0]};
                sum = sum + (sum >> 16);
                fw_hdr[W_CSUM] = ~sum[15:0];
                for (int i = 0; i < fw_need && i < HDR_MAX; i++) begin
                    push_egress(V_FORWARD, fw_hdr[i], (i + 1 == fw_need), hop, fw_own_mac);
                end
            end
        end
    endtask

    task automatic ingest_item(logic op, logic [2:0] slot, logic [31:0] addr,
                               logic [47:0] mac, logic en, logic [15:0] w);
        if (op == OP_ROUTE) begin
            route_writes++;
            if (int'(slot) < ROUTE_ENTRIES) begin
                fw_rt_addr[slot]  = addr;
                fw_rt_mac[slot]   = mac;
                fw_rt_valid[slot] = en;
            end
        end else if (fw_seen == 0 && w[11:8] < IHL_MIN) begin
            // header length field too short, wait for a fresh first word
            push_egress(V_MALFORMED, '0, 1'b1, '0, '0);
        end else begin
            if (fw_seen == 0) fw_need = int'(w[11:8]) * 2;
            if (fw_seen < HDR_MAX) fw_hdr[fw_seen] = w;
            fw_seen++;
            if (fw_seen >= fw_need) begin
                decide_and_rewrite();
                fw_seen = 0;
                fw_need = 0;
            end
        end
    endtask

    task automatic check_egress();
        egress_word_t want;
        if (egress_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected word verdict=%0d word=%h last=%b",
                                    o_verdict, o_out_word, o_out_last));
            return;
        end
        want = egress_q.pop_front();
        if (o_verdict !== want.verdict)
            flag_mismatch($sformatf("word %0d verdict: got %0d, expected %0d",
                                    words_checked, o_verdict, want.verdict));
        if (o_out_word !== want.word)
            flag_mismatch($sformatf("word %0d out_word: got %h, expected %h",
                                    words_checked, o_out_word, want.word));
        if (o_out_last !== want.last)
            flag_mismatch($sformatf("word %0d out_last: got %b, expected %b",
                                    words_checked, o_out_last, want.last));
        if (o_dst_mac_out !== want.dmac)
            flag_mismatch($sformatf("word %0d dst_mac: got %h, expected %h",
                                    words_checked, o_dst_mac_out, want.dmac));
        if (o_src_mac_out !== want.smac)
            flag_mismatch($sformatf("word %0d src_mac: got %h, expected %h",
                                    words_checked, o_src_mac_out, want.smac));
        words_checked++;
    endtask

    // sample both channels and the config port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fw_accept_src = '0;
            fw_own_mac    = '0;
            fw_seen       = 0;
            fw_need       = 0;
            for (int i = 0; i < ROUTE_ENTRIES; i++) begin
                fw_rt_addr[i]  = '0;
                fw_rt_mac[i]   = '0;
                fw_rt_valid[i] = 1'b0;
            end
            egress_q.delete();
        end else begin
            if (o_out_valid && i_out_ready) check_egress();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACCEPTED_SOURCE) fw_accept_src = i_cfg_data[31:0];
                else fw_own_mac = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                ingest_item(i_opcode, i_route_slot, i_route_address,
                            i_route_next_hop, i_route_enable, i_header_word);
            end
        end
    end

    // receiver side: random stalls, or a long hold-off on request
    initial begin : rx_side
        int n;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // cycle watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still awaited",
                 cycle_count, egress_q.size());
        $display("tb_ipv4_forward_header_rewrite_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // offer one word and hold it until the block takes it
    task automatic send_item(logic op, logic [2:0] slot, logic [31:0] addr,
                             logic [47:0] mac, logic en, logic [15:0] w);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_route_slot     <= slot;
        i_route_address  <= addr;
        i_route_next_hop <= mac;
        i_route_enable   <= en;
        i_header_word    <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_word(logic [15:0] w);
        send_item(OP_WORD, 3'($urandom), $urandom, rand48(), 1'($urandom), w);
    endtask

    task automatic send_route(int slot, logic [31:0] addr, logic [47:0] mac, logic en);
        send_item(OP_ROUTE, 3'(slot), addr, mac, en, 16'($urandom));
    endtask

    // mostly rewrites a slot with its pool address, so lookups keep hitting
    task automatic send_random_route();
        int slot;
        slot = $urandom_range(0, ROUTE_ENTRIES - 1);
        send_route(slot, ($urandom_range(0, 3) != 0) ? dst_pool[slot] : $urandom,
                   rand48(), ($urandom_range(0, 3) != 0));
    endtask

    function automatic hdr_words_t build_header(int ihl, logic [31:0] src,
                                                logic [31:0] dst, logic [7:0] ttl);
        hdr_words_t w;
        for (int i = 0; i < HDR_MAX; i++) w[i] = 16'($urandom);
        w[0][11:8]       = 4'(ihl);
        w[W_TTL][15:8]   = ttl;
        w[W_SRC_HI]      = src[31:16];
        w[W_SRC_LO]      = src[15:0];
        w[W_DST_HI]      = dst[31:16];
        w[W_DST_LO]      = dst[15:0];
        return w;
    endfunction

    task automatic send_header(int ihl, logic [31:0] src, logic [31:0] dst,
                               logic [7:0] ttl, bit mix_routes);
        hdr_words_t w;
        w = build_header(ihl, src, dst, ttl);
        for (int i = 0; i < ihl * 2; i++) begin
            if (mix_routes && $urandom_range(0, 5) == 0) send_random_route();
            send_word(w[i]);
        end
    endtask

    task automatic send_malformed(int ihl);
        send_word({4'($urandom), 4'(ihl), 8'($urandom)});
    endtask

    // route write slipped in just before the last header word
    task automatic send_split_header(logic [31:0] src, logic [31:0] dst, int slot,
                                     logic [47:0] mac, logic en);
        hdr_words_t w;
        w = build_header(IHL_MIN, src, dst, 8'd64);
        for (int i = 0; i < IHL_MIN * 2; i++) begin
            if (i == IHL_MIN * 2 - 1) send_route(slot, dst, mac, en);
            send_word(w[i]);
        end
    endtask

    // stop offering, wait for every awaited word, then let the block settle
    task automatic drain_egress();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (egress_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [47:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: source 0 accepted, empty table, zero own mac
    task automatic test_reset_state();
        send_header(IHL_MIN, 32'd0, dst_pool[0], 8'd64, 1'b0);
        send_header(IHL_MIN, $urandom | 32'd1, dst_pool[0], 8'd64, 1'b0);
        drain_egress();
    endtask

    task automatic test_directed_cases();
        logic [31:0] src;
        write_cfg(CFG_ACCEPTED_SOURCE, rand48());
        write_cfg(CFG_OWN_MAC, rand48());
        src = fw_accept_src;
        // duplicate address in slots 1 and 2, disabled match in slot 3
        send_route(0, dst_pool[0], rand48(), 1'b1);
        send_route(1, dst_pool[1], rand48(), 1'b1);
        send_route(2, dst_pool[1], rand48(), 1'b1);
        send_route(3, dst_pool[2], rand48(), 1'b0);
        send_route(5, dst_pool[2], rand48(), 1'b1);
        send_route(7, dst_pool[3], rand48(), 1'b1);
        send_route(4, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_route(6, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1);
        // forwards, including the longest header and ttl of two
        send_header(IHL_MIN, src, dst_pool[0], 8'd64, 1'b0);
        send_header(IHL_MIN, src, dst_pool[1], 8'd255, 1'b0);
        send_header(IHL_MIN, src, dst_pool[2], 8'd2, 1'b0);
        send_header(15, src, dst_pool[3], 8'd128, 1'b0);
        send_header(6, src, 32'h0000_0000, 8'd2, 1'b0);
        send_header(IHL_MIN, src, 32'hFFFF_FFFF, 8'd3, 1'b0);
        // drops and their order of precedence
        send_header(IHL_MIN, src, dst_pool[0], 8'd1, 1'b0);
        send_header(IHL_MIN, src, dst_pool[0], 8'd0, 1'b0);
        send_header(IHL_MIN, ~src, dst_pool[0], 8'd0, 1'b0);
        send_header(IHL_MIN, src, $urandom, 8'd0, 1'b0);
        send_header(IHL_MIN, src, $urandom, 8'd64, 1'b0);
        send_malformed(0);
        send_malformed(4);
        // route written mid-header is seen by its lookup, then withdrawn
        send_split_header(src, dst_pool[4], 6, rand48(), 1'b1);
        send_split_header(src, dst_pool[4], 6, rand48(), 1'b0);
        drain_egress();
        // all-ones registers
        write_cfg(CFG_ACCEPTED_SOURCE, 48'hFFFF_FFFF_FFFF);
        write_cfg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        send_header(IHL_MIN, 32'hFFFF_FFFF, dst_pool[0], 8'd64, 1'b0);
        drain_egress();
        // all-zero registers
        write_cfg(CFG_ACCEPTED_SOURCE, 48'd0);
        write_cfg(CFG_OWN_MAC, 48'd0);
        send_header(IHL_MIN, 32'd0, dst_pool[1], 8'd64, 1'b0);
        drain_egress();
    endtask

    task automatic test_random_traffic(int n_items);
        int          target;
        int          r;
        int          ihl;
        bit          mix;
        logic [31:0] src;
        pkt_kind_e   kind;
        for (int ph = 0; ph < 4; ph++) begin
            drain_egress();
            write_cfg(CFG_ACCEPTED_SOURCE, rand48());
            write_cfg(CFG_OWN_MAC, rand48());
            src = fw_accept_src;
            for (int s = 0; s < ROUTE_ENTRIES; s++) begin
                send_route(s, dst_pool[s], rand48(), ($urandom_range(0, 4) != 0));
            end
            target = items_sent + n_items / 4;
            while (items_sent < target) begin
                // quiet stretches now and then on either side
                tx_gaps   = ($urandom_range(0, 5) != 0);
                rx_stalls = ($urandom_range(0, 5) != 0);
                ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                  : $urandom_range(5, 7);
                mix = ($urandom_range(0, 7) == 0);
                r   = $urandom_range(0, 99);
                if (r < 55)      kind = PK_FORWARD;
                else if (r < 65) kind = PK_WRONG_SRC;
                else if (r < 73) kind = PK_TTL_LOW;
                else if (r < 81) kind = PK_NO_ROUTE;
                else if (r < 88) kind = PK_MALFORMED;
                else if (r < 95) kind = PK_ROUTE;
                else             kind = PK_NOISE;
                case (kind)
                    PK_FORWARD: begin
                        send_header(ihl, src, dst_pool[$urandom_range(0, ROUTE_ENTRIES - 1)],
                                    8'($urandom_range(2, 255)), mix);
                    end
                    PK_WRONG_SRC: begin
                        send_header(ihl, src ^ ($urandom | 32'd1),
                                    dst_pool[$urandom_range(0, ROUTE_ENTRIES - 1)],
                                    8'($urandom), mix);
                    end
                    PK_TTL_LOW: begin
                        send_header(ihl, src, dst_pool[$urandom_range(0, ROUTE_ENTRIES - 1)],
                                    8'($urandom_range(0, 1)), mix);
                    end
                    PK_NO_ROUTE: begin
                        send_header(ihl, src, $urandom, 8'($urandom_range(2, 255)), mix);
                    end
                    PK_MALFORMED: begin
                        send_malformed($urandom_range(0, 4));
                    end
                    PK_ROUTE: begin
                        send_random_route();
                    end
                    default: begin
                        send_header(ihl, $urandom, $urandom, 8'($urandom), 1'b1);
                    end
                endcase
            end
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        drain_egress();
    endtask

    // receiver holds off while headers keep coming, so the input backs up
    task automatic test_output_hold();
        logic [31:0] src;
        src = fw_accept_src;
        for (int s = 0; s < ROUTE_ENTRIES; s++) send_route(s, dst_pool[s], rand48(), 1'b1);
        hold_req = HOLD_CYCLES;
        for (int p = 0; p < HOLD_PACKETS; p++) begin
            send_header($urandom_range(5, 15), src,
                        dst_pool[$urandom_range(0, ROUTE_ENTRIES - 1)],
                        8'($urandom_range(2, 255)), 1'b0);
        end
        drain_egress();
    endtask

    // no idling on either side
    task automatic test_flat_out(int n_items);
        int          target;
        logic [31:0] src;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        src       = fw_accept_src;
        target    = items_sent + n_items;
        while (items_sent < target) begin
            send_header($urandom_range(5, 6), src,
                        dst_pool[$urandom_range(0, ROUTE_ENTRIES - 1)],
                        8'($urandom), 1'b0);
        end
        drain_egress();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_ACCEPTED_SOURCE;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_opcode         <= OP_WORD;
        i_route_slot     <= '0;
        i_route_address  <= '0;
        i_route_next_hop <= '0;
        i_route_enable   <= 1'b0;
        i_header_word    <= '0;
        for (int i = 0; i < 8; i++) verdict_tally[i] = 0;
        for (int i = 0; i < ROUTE_ENTRIES; i++) dst_pool[i] = $urandom;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_cases();
        test_random_traffic(RANDOM_ITEMS);
        test_output_hold();
        test_flat_out(FLAT_ITEMS);

        if (egress_q.size() != 0)
            flag_mismatch($sformatf("%0d egress words never arrived", egress_q.size()));
        $display("covered %0d input words (%0d route writes), %0d egress words checked",
                 items_sent, route_writes, words_checked);
        $display("forwarded %0d, wrong source %0d, ttl expired %0d, no route %0d, malformed %0d",
                 verdict_tally[V_FORWARD], verdict_tally[V_WRONG_SRC], verdict_tally[V_TTL],
                 verdict_tally[V_NO_ROUTE], verdict_tally[V_MALFORMED]);
        if (err_count == 0) begin
            $display("tb_ipv4_forward_header_rewrite_top: PASS");
        end else begin
            $display("tb_ipv4_forward_header_rewrite_top: FAIL");
        end
        $finish;
    end

endmodule
